// ----- rtl/smjh_pkg.sv -----
// ----------------------------------------------------------------------------
// smjh_pkg
// Shared types and constants for the sorted merge joint histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package smjh_pkg;

  // Default build values
  localparam int BINS_PER_AXIS_DEF = 1024;
  localparam int KEY_BITS_DEF      = 64;
  localparam int COUNTER_BITS_DEF  = 48;

  // Fixed field widths of the ports
  localparam int KEY_W   = 64;
  localparam int CNT_W   = 16;
  localparam int LIM_W   = 10;
  localparam int RC_W    = 10;
  localparam int BIN_W   = 48;
  localparam int CFG_IDX_W = 1;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(1000);

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_A = 1'b0,
    REG_LIMIT_B = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key_a;
    logic [CNT_W-1:0] count_a;
    logic             a_valid;
    logic [KEY_W-1:0] key_b;
    logic [CNT_W-1:0] count_b;
    logic             b_valid;
    logic [RC_W-1:0]  read_row;
    logic [RC_W-1:0]  read_col;
  } req_t;

  typedef struct packed {
    logic             advance_a;
    logic             advance_b;
    logic             both_done;
    logic [BIN_W-1:0] bin_value;
  } result_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic is_read;    // bin read request
    logic rd_zero;    // read outside the histogram, returns zero
    logic bin_en;     // compare step that bumps a bin
    logic advance_a;
    logic advance_b;
    logic both_done;
  } cmd_flags_t;

  // Request type codes
  localparam logic REQ_COMPARE = 1'b0;
  localparam logic REQ_READ    = 1'b1;

endpackage : smjh_pkg

`default_nettype wire

// ----- rtl/smjh_front.sv -----
// ----------------------------------------------------------------------------
// smjh_front
// Accepts request beats, compares keys, checks limits and builds the bin
// address. Holds the limit registers.
// ----------------------------------------------------------------------------
`default_nettype none

module smjh_front import smjh_pkg::*; #(
  parameter int BINS_PER_AXIS = BINS_PER_AXIS_DEF,
  parameter int KEY_BITS      = KEY_BITS_DEF,
  localparam int IDX_W        = $clog2(BINS_PER_AXIS),
  localparam int ADDR_W       = 2 * IDX_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire req_t                 in_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LIM_W-1:0]     cfg_wdata,
  input  wire logic                 clr_busy,
  input  wire logic                 q_full,
  output logic                      q_push,
  output cmd_flags_t                q_flags,
  output logic [ADDR_W-1:0]         q_addr
);

  localparam logic [CNT_W-1:0] LIM_MAX  = CNT_W'(BINS_PER_AXIS - 1);
  localparam logic [CNT_W-1:0] BINS_CNT = CNT_W'(BINS_PER_AXIS);

  logic [LIM_W-1:0]  limit_a_r, limit_a_nxt;
  logic [LIM_W-1:0]  limit_b_r, limit_b_nxt;
  logic              f_v_r, f_v_nxt;
  cmd_flags_t        f_flags_r, f_flags_nxt;
  logic [ADDR_W-1:0] f_addr_r, f_addr_nxt;

  logic              accept;
  logic [CNT_W-1:0]  eff_a, eff_b;
  logic [KEY_BITS-1:0] ka, kb;
  logic              ok_a, ok_b;
  logic [CNT_W-1:0]  row16, col16;

  assign cfg_ready = 1'b1;
  assign q_push    = f_v_r & ~q_full;
  assign in_stall  = clr_busy | (f_v_r & q_full);
  assign accept    = in_valid & ~in_stall;

  assign q_flags = f_flags_r;
  assign q_addr  = f_addr_r;

  // Clamp limits to the last bin
  always_comb begin
    eff_a = ({6'd0, limit_a_r} > LIM_MAX) ? LIM_MAX : {6'd0, limit_a_r};
    eff_b = ({6'd0, limit_b_r} > LIM_MAX) ? LIM_MAX : {6'd0, limit_b_r};
  end

  assign ka   = in_data.key_a[KEY_BITS-1:0];
  assign kb   = in_data.key_b[KEY_BITS-1:0];
  assign ok_a = (in_data.count_a <= eff_a);
  assign ok_b = (in_data.count_b <= eff_b);

  always_comb begin
    f_flags_nxt = '0;
    row16       = '0;
    col16       = '0;
    if (in_data.req_type == REQ_READ) begin
      f_flags_nxt.is_read = 1'b1;
      row16 = CNT_W'(in_data.read_row);
      col16 = CNT_W'(in_data.read_col);
      f_flags_nxt.rd_zero = (row16 >= BINS_CNT) | (col16 >= BINS_CNT);
    end else if (!in_data.a_valid && !in_data.b_valid) begin
      f_flags_nxt.both_done = 1'b1;
    end else if (in_data.a_valid && (!in_data.b_valid || ka < kb)) begin
      f_flags_nxt.advance_a = 1'b1;
      f_flags_nxt.bin_en    = ok_a;
      col16 = in_data.count_a;
    end else if (in_data.b_valid && (!in_data.a_valid || kb < ka)) begin
      f_flags_nxt.advance_b = 1'b1;
      f_flags_nxt.bin_en    = ok_b;
      row16 = in_data.count_b;
    end else begin
      f_flags_nxt.advance_a = 1'b1;
      f_flags_nxt.advance_b = 1'b1;
      f_flags_nxt.bin_en    = ok_a & ok_b;
      row16 = in_data.count_b;
      col16 = in_data.count_a;
    end
    f_addr_nxt = {row16[IDX_W-1:0], col16[IDX_W-1:0]};
  end

  assign f_v_nxt = accept | (f_v_r & ~q_push);

  always_comb begin
    limit_a_nxt = limit_a_r;
    limit_b_nxt = limit_b_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LIMIT_A: limit_a_nxt = cfg_wdata;
        REG_LIMIT_B: limit_b_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_a_r <= LIMIT_RESET;
      limit_b_r <= LIMIT_RESET;
      f_v_r     <= 1'b0;
    end else begin
      limit_a_r <= limit_a_nxt;
      limit_b_r <= limit_b_nxt;
      f_v_r     <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_flags_r <= f_flags_nxt;
      f_addr_r  <= f_addr_nxt;
    end
  end

endmodule : smjh_front

`default_nettype wire

// ----- rtl/smjh_queue.sv -----
// ----------------------------------------------------------------------------
// smjh_queue
// Small register FIFO between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module smjh_queue import smjh_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_QW = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      head_data,
  output logic                   empty
);

  logic [DATA_W-1:0] ent_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_QW'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_data = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_QW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue fill count lost a push");

endmodule : smjh_queue

`default_nettype wire

// ----- rtl/smjh_back.sv -----
// ----------------------------------------------------------------------------
// smjh_back
// Histogram memory with clearing pass, read-modify-write with forwarding,
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smjh_back import smjh_pkg::*; #(
  parameter int BINS_PER_AXIS = BINS_PER_AXIS_DEF,
  parameter int COUNTER_BITS  = COUNTER_BITS_DEF,
  localparam int IDX_W        = $clog2(BINS_PER_AXIS),
  localparam int ADDR_W       = 2 * IDX_W,
  localparam int MEM_DEPTH    = 1 << ADDR_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire cmd_flags_t        q_flags,
  input  wire logic [ADDR_W-1:0] q_addr,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output result_t                out_data,
  output logic                   clr_busy
);

  logic [COUNTER_BITS-1:0] mem [MEM_DEPTH];
  logic [COUNTER_BITS-1:0] rd_data_r;

  logic                    clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0]       clr_addr_r, clr_addr_nxt;

  logic                    ex_v_r, ex_v_nxt;
  cmd_flags_t              ex_flags_r;
  logic [ADDR_W-1:0]       ex_addr_r;

  logic [ADDR_W-1:0]       lw_addr_r;
  logic [COUNTER_BITS-1:0] lw_data_r;

  logic                    out_valid_r, out_valid_nxt;
  result_t                 out_data_r, out_data_nxt;

  logic                    adv;
  logic [COUNTER_BITS-1:0] cur, bumped;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [COUNTER_BITS-1:0] mem_wdata;

  assign clr_busy  = clr_busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Advance when the output register is free or being taken
  assign adv   = ~out_valid_r | ~out_stall;
  assign q_pop = adv & ~q_empty;

  // Forward the last write: it may have hit the same bin at the read edge
  assign cur    = (lw_addr_r == ex_addr_r) ? lw_data_r : rd_data_r;
  assign bumped = (&cur) ? cur : cur + 1'b1;

  always_comb begin
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = adv & ex_v_r & ex_flags_r.bin_en;
      mem_waddr = ex_addr_r;
      mem_wdata = bumped;
    end
  end

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  assign ex_v_nxt = adv ? ~q_empty : ex_v_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (adv) begin
      out_valid_nxt          = ex_v_r;
      out_data_nxt.advance_a = ex_flags_r.advance_a;
      out_data_nxt.advance_b = ex_flags_r.advance_b;
      out_data_nxt.both_done = ex_flags_r.both_done;
      out_data_nxt.bin_value = (ex_flags_r.is_read && !ex_flags_r.rd_zero) ?
                               BIN_W'(cur) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      ex_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      ex_v_r      <= ex_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (q_pop) begin
      ex_flags_r <= q_flags;
      ex_addr_r  <= q_addr;
    end
    if (mem_we) begin
      lw_addr_r <= mem_waddr;
      lw_data_r <= mem_wdata;
    end
  end

  // Histogram memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      rd_data_r <= mem[q_addr];
    end
  end

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !ex_v_r && !q_pop)
    else $error("item in flight during clearing pass");

  a_compare_zero_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.advance_a || out_data_r.advance_b ||
                    out_data_r.both_done) |-> out_data_r.bin_value == '0)
    else $error("compare result carries a bin value");

  a_done_no_adv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.both_done |->
      !out_data_r.advance_a && !out_data_r.advance_b)
    else $error("done result also advances a table");

endmodule : smjh_back

`default_nettype wire

// ----- rtl/sorted_merge_joint_histogram.sv -----
// ----------------------------------------------------------------------------
// sorted_merge_joint_histogram
// Merge join over two key-sorted k-mer tables that bins matching counts into
// a saturating two-dimensional histogram, with single-bin reads.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Beat
//  --------+-----------+-----------------------+------------------------------
//  in_     | in        | in_valid / in_stall   | req_t: compare step or bin read
//  out_    | out       | out_valid / out_stall | result_t: advance/done/bin
//  cfg_    | in        | cfg_valid / cfg_ready | register index + limit value
//
//  One beat per cycle sustained while no stall or clearing pass holds it;
//  a request's result passes the front register, queue, memory read and
//  output register in turn. The histogram memory's single read-modify-write
//  port sets that rate; back-to-back hits on one bin are forwarded from the last
//  write. After reset a clearing pass zeroes all (2**clog2(BINS_PER_AXIS))**2
//  bins, one bin per cycle; in_stall is high meanwhile, cfg writes are taken.
//  An out_stall holds the back end; the queue keeps accepting until it fills.
//
`default_nettype none

module sorted_merge_joint_histogram import smjh_pkg::*; #(
  parameter int BINS_PER_AXIS = BINS_PER_AXIS_DEF,
  parameter int KEY_BITS      = KEY_BITS_DEF,
  parameter int COUNTER_BITS  = COUNTER_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire req_t                 in_data,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output result_t                   out_data,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LIM_W-1:0]     cfg_wdata
);

  localparam int IDX_W  = $clog2(BINS_PER_AXIS);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int Q_W    = $bits(cmd_flags_t) + ADDR_W;

  // front -> queue
  logic              push;
  cmd_flags_t        push_flags;
  logic [ADDR_W-1:0] push_addr;
  logic              q_full;

  // queue -> back
  logic              q_empty;
  logic              q_pop;
  logic [Q_W-1:0]    q_head;
  cmd_flags_t        head_flags;
  logic [ADDR_W-1:0] head_addr;

  logic              clr_busy;

  assign head_flags = cmd_flags_t'(q_head[Q_W-1 -: $bits(cmd_flags_t)]);
  assign head_addr  = q_head[ADDR_W-1:0];

  // Classify: key compare, limit checks, bin address
  smjh_front #(
    .BINS_PER_AXIS (BINS_PER_AXIS),
    .KEY_BITS      (KEY_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .clr_busy  (clr_busy),
    .q_full    (q_full),
    .q_push    (push),
    .q_flags   (push_flags),
    .q_addr    (push_addr)
  );

  // Decouple front and back so each can stall on its own
  smjh_queue #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_flags, push_addr}),
    .full      (q_full),
    .pop       (q_pop),
    .head_data (q_head),
    .empty     (q_empty)
  );

  // Execute: bin update or read, then drive the result beat
  smjh_back #(
    .BINS_PER_AXIS (BINS_PER_AXIS),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_flags   (head_flags),
    .q_addr    (head_addr),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .clr_busy  (clr_busy)
  );

endmodule : sorted_merge_joint_histogram

`default_nettype wire

// ----- verif/hist_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hist_scoreboard_pkg
// Expected-result model of the sorted merge joint histogram: keeps its own
// copy of the bins and limits, and checks every result beat against it.
// ----------------------------------------------------------------------------
package hist_scoreboard_pkg;
  import smjh_pkg::*;

  localparam longint unsigned COUNTER_TOP = (64'd1 << COUNTER_BITS_DEF) - 64'd1;
  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS_DEF >= KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << KEY_BITS_DEF) - 1);
  localparam int unsigned MAX_BIN = BINS_PER_AXIS_DEF - 1;
  localparam int MAX_PRINTED = 100;

  class hist_scoreboard;
    longint unsigned  hist[longint unsigned];
    result_t          expected_q[$];
    logic [LIM_W-1:0] lim_a;
    logic [LIM_W-1:0] lim_b;
    int               errors;

    function new();
      lim_a  = LIMIT_RESET;
      lim_b  = LIMIT_RESET;
      errors = 0;
    endfunction

    function void set_limit(cfg_reg_t which, logic [LIM_W-1:0] value);
      if (which == REG_LIMIT_A) begin
        lim_a = value;
      end else begin
        lim_b = value;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int unsigned clamp_limit(logic [LIM_W-1:0] lim);
      return (lim > MAX_BIN) ? MAX_BIN : int'(lim);
    endfunction

    // Drop counts past either limit; hold a full counter at its top value.
    function void bump(int unsigned row, int unsigned col);
      longint unsigned at;
      if (row > clamp_limit(lim_b) || col > clamp_limit(lim_a)) return;
      at = longint'(row) * BINS_PER_AXIS_DEF + longint'(col);
      if (!hist.exists(at)) hist[at] = 0;
      if (hist[at] < COUNTER_TOP) hist[at] = hist[at] + 1;
    endfunction

    // Record an accepted request beat and return the result it must produce.
    function result_t note_request(req_t r);
      result_t          res;
      longint unsigned  at;
      longint unsigned  val;
      logic [KEY_W-1:0] ka;
      logic [KEY_W-1:0] kb;
      res = '0;
      ka  = r.key_a & KEY_MASK;
      kb  = r.key_b & KEY_MASK;
      if (r.req_type == REQ_READ) begin
        if (r.read_row < BINS_PER_AXIS_DEF && r.read_col < BINS_PER_AXIS_DEF) begin
          at  = longint'(r.read_row) * BINS_PER_AXIS_DEF + longint'(r.read_col);
          val = hist.exists(at) ? hist[at] : 64'd0;
          res.bin_value = val[BIN_W-1:0];
        end
      end else if (!r.a_valid && !r.b_valid) begin
        res.both_done = 1'b1;
      end else if (r.a_valid && (!r.b_valid || ka < kb)) begin
        bump(0, 32'(r.count_a));
        res.advance_a = 1'b1;
      end else if (r.b_valid && (!r.a_valid || kb < ka)) begin
        bump(32'(r.count_b), 0);
        res.advance_b = 1'b1;
      end else begin
        bump(32'(r.count_b), 32'(r.count_a));
        res.advance_a = 1'b1;
        res.advance_b = 1'b1;
      end
      expected_q.push_back(res);
      return res;
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat %h with nothing outstanding", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.advance_a !== want.advance_a)
        report($sformatf("advance_a got %b want %b", got.advance_a, want.advance_a));
      if (got.advance_b !== want.advance_b)
        report($sformatf("advance_b got %b want %b", got.advance_b, want.advance_b));
      if (got.both_done !== want.both_done)
        report($sformatf("both_done got %b want %b", got.both_done, want.both_done));
      if (got.bin_value !== want.bin_value)
        report($sformatf("bin_value got %0d want %0d", got.bin_value, want.bin_value));
    endtask
  endclass

endpackage : hist_scoreboard_pkg

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted merge joint histogram. A directed burst
// covers key order corner cases, limit edges and back-to-back bin hits; then
// phases with different count limits stream whole key-sorted table pairs
// through the merge, mixed with bin reads, noise beats and skipped heads.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import smjh_pkg::*;
  import hist_scoreboard_pkg::*;

  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_PHASES      = 6;
  // Leave ample headroom beyond the clearing pass.
  localparam int CYCLE_LIMIT     = 4_000_000;
  // Pipeline is four deep; let it drain before touching registers.
  localparam int DRAIN_CYCLES    = 12;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  req_t                 in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  result_t              out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LIMIT_A;
  logic [LIM_W-1:0]     cfg_wdata = '0;

  hist_scoreboard sb = new();

  int          cycle_count = 0;
  int          stall_left  = 0;
  int          free_left   = 0;
  bit          in_gaps_on  = 1'b0;
  int unsigned cur_lim_a   = 32'(LIMIT_RESET);
  int unsigned cur_lim_b   = 32'(LIMIT_RESET);

  // Remaining entries of the two tables being merged, head at index 0.
  logic [KEY_W-1:0] tab_a_key[$];
  logic [CNT_W-1:0] tab_a_cnt[$];
  logic [KEY_W-1:0] tab_b_key[$];
  logic [CNT_W-1:0] tab_b_cnt[$];

  sorted_merge_joint_histogram dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check every accepted beat, then pick the next stall value.
  // Stalls come in short bursts with the odd long one, and now and then a
  // long stretch with no stall at all.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left <= free_left - 1;
    end else begin
      out_stall  <= 1'b0;
      free_left  <= ($urandom_range(0, 99) < 20) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 6);
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 50);
    end
  end

  function automatic logic [KEY_W-1:0] random64();
    return {$urandom, $urandom};
  endfunction

  // Random contents in every field; callers overwrite what matters.
  function automatic req_t junk_req();
    req_t r;
    r.req_type = 1'($urandom_range(0, 1));
    r.key_a    = random64();
    r.count_a  = CNT_W'($urandom_range(0, 65535));
    r.a_valid  = 1'($urandom_range(0, 1));
    r.key_b    = random64();
    r.count_b  = CNT_W'($urandom_range(0, 65535));
    r.b_valid  = 1'($urandom_range(0, 1));
    r.read_row = RC_W'($urandom_range(0, 1023));
    r.read_col = RC_W'($urandom_range(0, 1023));
    return r;
  endfunction

  function automatic req_t compare_req(bit va, logic [KEY_W-1:0] ka, logic [CNT_W-1:0] ca,
                                       bit vb, logic [KEY_W-1:0] kb, logic [CNT_W-1:0] cb);
    req_t r;
    r          = junk_req();
    r.req_type = REQ_COMPARE;
    r.a_valid  = va;
    r.key_a    = ka;
    r.count_a  = ca;
    r.b_valid  = vb;
    r.key_b    = kb;
    r.count_b  = cb;
    return r;
  endfunction

  function automatic req_t read_req(logic [RC_W-1:0] row, logic [RC_W-1:0] col);
    req_t r;
    r          = junk_req();
    r.req_type = REQ_READ;
    r.read_row = row;
    r.read_col = col;
    return r;
  endfunction

  // Mostly tiny counts so bins collide, some right at the limit edge, and
  // some anywhere in the 16-bit range.
  function automatic logic [CNT_W-1:0] pick_count(int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return CNT_W'($urandom_range(0, 6));
    if (r < 80) return CNT_W'(lim + $urandom_range(0, 2) - 1);
    return CNT_W'($urandom_range(0, 65535));
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (!in_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one request beat, hold it through stalls, and log it once taken.
  task automatic send_request(input req_t r, output result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = sb.note_request(r);
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    result_t          want;
    req_t             req;
    logic [CNT_W-1:0] c_row;
    logic [CNT_W-1:0] c_col;
    logic [LIM_W-1:0] lim_pair[2];
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] nk;
    cfg_reg_t         which;
    int               sent;
    int               n;
    int unsigned      pick;
    int unsigned      mode;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed burst at the reset limits. No input gaps, so repeated bins
    // land back to back and exercise forwarding. The first beat waits out
    // the clearing pass.
    send_request(compare_req(0, random64(), 16'd9, 0, random64(), 16'd9), want);
    send_request(compare_req(1, '0, 16'd0, 0, random64(), 16'd4), want);
    send_request(compare_req(0, random64(), 16'd4, 1, '0, 16'd5), want);
    // A lower at the limit; B lower with an unsigned-only order and over limit
    send_request(compare_req(1, '0, 16'd1000, 1, '1, 16'd3), want);
    send_request(compare_req(1, 64'h8000_0000_0000_0000, 16'd2,
                             1, 64'h7FFF_FFFF_FFFF_FFFF, 16'd1001), want);
    send_request(compare_req(1, '1, 16'd1000, 1, '1, 16'd1000), want);
    send_request(compare_req(1, '0, 16'hFFFF, 1, '0, 16'hFFFF), want);
    repeat (3) send_request(compare_req(1, 64'd42, 16'd3, 1, 64'd42, 16'd7), want);
    send_request(read_req(10'd7, 10'd3), want);
    send_request(compare_req(1, 64'd5, 16'd1001, 0, random64(), 16'd2), want);
    send_request(compare_req(0, random64(), 16'd2, 1, 64'd5, 16'd1001), want);
    send_request(read_req(10'd0, 10'd0), want);
    send_request(read_req(10'd5, 10'd0), want);
    send_request(read_req(10'd0, 10'd1000), want);
    send_request(read_req(10'd1000, 10'd1000), want);
    send_request(read_req(10'd1023, 10'd1023), want);
    send_request(read_req(10'd0, 10'd1001), want);
    send_request(read_req(10'd1001, 10'd0), want);
    send_request(compare_req(1, 64'd9, 16'd0, 0, random64(), 16'd0), want);
    send_request(read_req(10'd0, 10'd0), want);
    send_request(compare_req(1, 64'd11, 16'd0, 1, 64'd11, 16'd0), want);
    send_request(read_req(10'd0, 10'd0), want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      // Limits per phase: widest, zero, one axis at one, random, back to reset.
      case (ph)
        0: lim_pair = '{10'd1023, 10'd1023};
        1: lim_pair = '{10'd0, 10'd0};
        2: lim_pair = '{10'd1, 10'd1023};
        3: lim_pair = '{10'd1023, 10'd1};
        4: lim_pair = '{LIM_W'($urandom_range(1, 1022)), LIM_W'($urandom_range(1, 1022))};
        default: lim_pair = '{LIMIT_RESET, LIMIT_RESET};
      endcase
      for (int i = 0; i < 2; i++) begin
        which     = (i == 0) ? REG_LIMIT_A : REG_LIMIT_B;
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= lim_pair[i];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_limit(which, lim_pair[i]);
      end
      cfg_valid  <= 1'b0;
      cur_lim_a  = 32'(lim_pair[0]);
      cur_lim_b  = 32'(lim_pair[1]);
      in_gaps_on = ($urandom_range(0, 3) != 0);

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          if (tab_a_key.size() == 0 && tab_b_key.size() == 0) begin
            // Both tables exhausted: report done, then load a fresh pair.
            send_request(compare_req(0, random64(), pick_count(cur_lim_a),
                                     0, random64(), pick_count(cur_lim_b)), want);
            k = random64() >> $urandom_range(0, 63);
            if ($urandom_range(0, 9) == 0) k = 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(0, 63));
            n = $urandom_range(3, 30);
            for (int i = 0; i < n; i++) begin
              mode = $urandom_range(0, 99);
              // below 35: key in both tables; below 65: A only; else B only
              if (mode < 65) begin
                tab_a_key.push_back(k);
                tab_a_cnt.push_back(pick_count(cur_lim_a));
              end
              if (mode < 35 || mode >= 65) begin
                tab_b_key.push_back(k);
                tab_b_cnt.push_back(pick_count(cur_lim_b));
              end
              nk = k + (($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(1, 16)));
              if (nk <= k) break;
              k = nk;
            end
          end else begin
            // Present the current heads; advance as the merge directs.
            req = compare_req(tab_a_key.size() != 0,
                              (tab_a_key.size() != 0) ? tab_a_key[0] : random64(),
                              (tab_a_cnt.size() != 0) ? tab_a_cnt[0] : pick_count(cur_lim_a),
                              tab_b_key.size() != 0,
                              (tab_b_key.size() != 0) ? tab_b_key[0] : random64(),
                              (tab_b_cnt.size() != 0) ? tab_b_cnt[0] : pick_count(cur_lim_b));
            send_request(req, want);
            if (want.advance_a && tab_a_key.size() != 0) begin
              void'(tab_a_key.pop_front());
              void'(tab_a_cnt.pop_front());
            end
            if (want.advance_b && tab_b_key.size() != 0) begin
              void'(tab_b_key.pop_front());
              void'(tab_b_cnt.pop_front());
            end
          end
          sent++;
        end else if (pick < 92) begin
          c_row = pick_count(cur_lim_b);
          c_col = pick_count(cur_lim_a);
          send_request(read_req(c_row[RC_W-1:0], c_col[RC_W-1:0]), want);
          sent++;
        end else if (pick < 97) begin
          // Noise: a compare beat unrelated to the tables.
          req          = junk_req();
          req.req_type = REQ_COMPARE;
          send_request(req, want);
          sent++;
        end else if (tab_a_key.size() != 0 && $urandom_range(0, 1) == 0) begin
          // Broken sequence: skip a head of A without telling the block.
          void'(tab_a_key.pop_front());
          void'(tab_a_cnt.pop_front());
        end else if (tab_b_key.size() != 0) begin
          void'(tab_b_key.pop_front());
          void'(tab_b_cnt.pop_front());
        end
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule : tb_top
